// ----- rtl/core/sparse_matrix_element_lookup_assert.svh -----
// Assertion macros used by the lookup RTL.
`ifndef SPARSE_MATRIX_ELEMENT_LOOKUP_ASSERT_SVH
`define SPARSE_MATRIX_ELEMENT_LOOKUP_ASSERT_SVH

// same-cycle implication
`define SMEL_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sparse matrix lookup: assertion failed");

// next-cycle implication
`define SMEL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sparse matrix lookup: assertion failed");

`endif

// ----- rtl/core/smel_pkg.sv -----
`default_nettype none
package smel_pkg;

   localparam int unsigned ENTRIES_DEF = 4096;
   localparam int unsigned IDX_W       = 16;
   localparam int unsigned KEY_W       = 32;
   localparam int unsigned VAL_W       = 32;
   localparam int unsigned ENTRY_W     = KEY_W + VAL_W;

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_QUERY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      kind_type          kind;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  column;
      logic [VAL_W-1:0]  entry_value;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0]  read_value;
      logic              found;
      status_type        status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHIFT,
      ST_PLACE,
      ST_RESULT
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/core/sparse_matrix_element_lookup.sv -----
// Clear, kind 3 and rejected requests go from decode straight to the result state. A query
// takes at most ceil(log2(n+1)) search steps for n stored entries (12 at 4095); a load also
// moves the entries above its place up and then writes the new entry. One request at a time:
// the next one is accepted only after the response is loaded. A search step is a read plus
// a compare, the insertion move copies one entry per cycle. Reset clears the FSM, entry count
// and response valid and sets matrix_size to 1; the entry memory itself is not cleared.
`default_nettype none
`include "sparse_matrix_element_lookup_assert.svh"

module sparse_matrix_element_lookup #(
   parameter int unsigned ENTRIES = smel_pkg::ENTRIES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire smel_pkg::req_type         req_data,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      smel_pkg::rsp_type         rsp_data,
   input  wire logic                      csr_wr_en,
   input  wire logic [smel_pkg::IDX_W-1:0] csr_wr_data
);
   import smel_pkg::*;

   localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   rsp_type              res_ff, res_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     size_ff, size_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [CW-1:0]        rd_idx_ff, rd_idx_in;
   logic [CW-1:0]        mv_addr_ff, mv_addr_in;
   logic                 mv_pend_ff, mv_pend_in;
   logic [KEY_W-1:0]     key_ff, key_in;

   logic [ENTRY_W-1:0]   mem [0:ENTRIES-1];
   logic [ENTRY_W-1:0]   rd_data_ff;
   logic                 mem_re, mem_we;
   logic [AW-1:0]        mem_raddr, mem_waddr;
   logic [ENTRY_W-1:0]   mem_wdata;

   logic [CW-1:0]        mid;
   logic [KEY_W-1:0]     km;
   logic                 go_right;
   logic                 out_of_range;
   logic                 is_load;
   logic                 rsp_load;

   assign mid          = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign km           = rd_data_ff[VAL_W +: KEY_W];
   assign is_load      = (req_ff.kind == KIND_LOAD);
   // loads go after equal keys, queries stop at the first equal key
   assign go_right     = is_load ? (km <= key_ff) : (km < key_ff);
   assign out_of_range = (req_ff.row >= size_ff) || (req_ff.column >= size_ff);
   assign rsp_load     = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_ready);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if ((req_ff.kind == KIND_LOAD || req_ff.kind == KIND_QUERY) && !out_of_range
                && !(is_load && count_ff >= CW'(ENTRIES)))
               state_in = ST_SRCH_RD;
            else
               state_in = ST_RESULT;
         end
         ST_SRCH_RD: begin
            if (lo_ff < hi_ff) state_in = ST_SRCH_CMP;
            else if (is_load)  state_in = ST_SHIFT;
            else               state_in = ST_RESULT;
         end
         ST_SRCH_CMP: state_in = ST_SRCH_RD;
         ST_SHIFT: begin
            if (n_ff == '0) state_in = ST_PLACE;
         end
         ST_PLACE: state_in = ST_RESULT;
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_in       = req_ff;
      res_in       = res_ff;
      size_in      = csr_wr_en ? csr_wr_data : size_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      n_in         = n_ff;
      rd_idx_in    = rd_idx_ff;
      mv_addr_in   = mv_addr_ff;
      mv_pend_in   = 1'b0;
      key_in       = key_ff;
      mem_re       = 1'b0;
      mem_raddr    = mid[AW-1:0];
      mem_we       = 1'b0;
      mem_waddr    = lo_ff[AW-1:0];
      mem_wdata    = {key_ff, req_ff.entry_value};
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) req_in = req_data;
         end
         ST_DECODE: begin
            res_in     = '0;
            key_in     = {{(KEY_W-IDX_W){1'b0}}, req_ff.row} *
                         {{(KEY_W-IDX_W){1'b0}}, size_ff} +
                         {{(KEY_W-IDX_W){1'b0}}, req_ff.column};
            lo_in      = '0;
            hi_in      = count_ff;
            unique case (req_ff.kind)
               KIND_CLEAR: count_in = '0;
               KIND_LOAD, KIND_QUERY: begin
                  if (out_of_range)                     res_in.status = STAT_RANGE;
                  else if (is_load && count_ff >= CW'(ENTRIES)) res_in.status = STAT_FULL;
               end
               default: ;
            endcase
         end
         ST_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               mem_re = 1'b1;
            end else begin
               n_in      = count_ff - lo_ff;
               rd_idx_in = count_ff - CW'(1);
            end
         end
         ST_SRCH_CMP: begin
            if (go_right) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
               // the last upper-bound probe is the lower-bound place
               res_in.found      = (km == key_ff) && !is_load;
               res_in.read_value = ((km == key_ff) && !is_load) ?
                                   rd_data_ff[VAL_W-1:0] : '0;
            end
         end
         ST_SHIFT: begin
            // read entry i while entry i+1 from the previous read is written
            if (n_ff != '0) begin
               mem_re     = 1'b1;
               mem_raddr  = rd_idx_ff[AW-1:0];
               rd_idx_in  = rd_idx_ff - CW'(1);
               n_in       = n_ff - CW'(1);
               mv_pend_in = 1'b1;
               mv_addr_in = rd_idx_ff + CW'(1);
            end
            if (mv_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = mv_addr_ff[AW-1:0];
               mem_wdata = rd_data_ff;
            end
         end
         ST_PLACE: begin
            mem_we   = 1'b1;
            count_in = count_ff + CW'(1);
         end
         ST_RESULT: begin
            if (rsp_load) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         size_ff      <= IDX_W'(1);
         count_ff     <= '0;
         mv_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         mv_pend_ff   <= mv_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      n_ff       <= n_in;
      rd_idx_ff  <= rd_idx_in;
      mv_addr_ff <= mv_addr_in;
      key_ff     <= key_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

   `SMEL_ASSERT_NOW(a_count_max, 1'b1, count_ff <= CW'(ENTRIES))
   `SMEL_ASSERT_NOW(a_search_bounds,
      (state_ff == ST_SRCH_RD || state_ff == ST_SRCH_CMP), lo_ff <= hi_ff)
   `SMEL_ASSERT_NOW(a_hit_ok, (rsp_valid_ff && rsp_ff.found), rsp_ff.status == STAT_OK)
   `SMEL_ASSERT_NEXT(a_probe, (state_ff == ST_SRCH_RD && lo_ff < hi_ff),
      state_ff == ST_SRCH_CMP)
   `SMEL_ASSERT_NEXT(a_insert_count, (state_ff == ST_PLACE),
      count_ff == $past(count_ff) + CW'(1))

endmodule
`default_nettype wire
